FILE: rtl/core/kofn_pkg.sv
`default_nettype none

package kofn_pkg;

    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = 17;
    localparam int COST_BITS      = 16;
    localparam int COST_W         = 16;
    localparam int PREFIX_W       = 22;
    localparam int ACC_W          = 38;
    localparam int TERM_W         = PROB_W + PREFIX_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 7;
    localparam int DEF_MAX_VARS   = 64;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_K    = 2'd0,
        REG_VARIABLE_COUNT = 2'd1,
        REG_COST_MODE      = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_TERM,
        S_ACC
    } t_state;

    typedef struct packed {
        logic [PROB_W-1:0] probability_one;
        logic [COST_W-1:0] test_cost;
    } t_in_word;

    typedef struct packed {
        logic [ACC_W-1:0] running_cost;
        logic             final_item;
    } t_out_word;

    typedef struct packed {
        logic mul_en;
        logic upd_en;
        logic clr;
    } t_cell_ctrl;

    function automatic logic [PROB_W-1:0] pmul(input logic [PROB_W-1:0] a,
                                               input logic [PROB_W-1:0] b);
        logic [2*PROB_W-1:0] prod;
        prod = a * b;
        return prod[PROB_FRAC_BITS +: PROB_W];
    endfunction

    function automatic logic [PROB_W-1:0] psat_add(input logic [PROB_W-1:0] a,
                                                   input logic [PROB_W-1:0] b);
        logic [PROB_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, PROB_ONE}) ? PROB_ONE : s[PROB_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/kofn_cell.sv
`default_nettype none

module kofn_cell
    import kofn_pkg::*;
#(
    parameter int IW       = 6,
    parameter int CELL_IDX = 0
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  t_cell_ctrl  i_ctrl,
    input  wire  [PROB_W-1:0] i_p,
    input  wire  [PROB_W-1:0] i_q,
    input  wire  [PROB_W-1:0] i_prev_one,
    input  wire  [PROB_W-1:0] i_prev_zero,
    input  wire  [IW-1:0]     i_ki,
    input  wire  [IW-1:0]     i_zi,
    output logic [PROB_W-1:0] o_one,
    output logic [PROB_W-1:0] o_zero,
    output logic [PROB_W-1:0] o_sel_one,
    output logic [PROB_W-1:0] o_sel_zero
);

    localparam logic [PROB_W-1:0] RST_VAL = (CELL_IDX == 0) ? PROB_ONE : '0;
    localparam logic [IW-1:0]     MY_IDX  = IW'(CELL_IDX);

    logic [PROB_W-1:0] r_one;
    logic [PROB_W-1:0] r_zero;
    logic [PROB_W-1:0] r_pa;
    logic [PROB_W-1:0] r_pb;
    logic [PROB_W-1:0] r_pc;
    logic [PROB_W-1:0] r_pd;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_pa <= pmul(i_prev_one, i_p);
            r_pb <= pmul(r_one, i_q);
            r_pc <= pmul(i_prev_zero, i_q);
            r_pd <= pmul(r_zero, i_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one  <= RST_VAL;
            r_zero <= RST_VAL;
        end else if (i_ctrl.clr) begin
            r_one  <= RST_VAL;
            r_zero <= RST_VAL;
        end else if (i_ctrl.upd_en) begin
            r_one  <= psat_add(r_pa, r_pb);
            r_zero <= psat_add(r_pc, r_pd);
        end
    end

    assign o_one      = r_one;
    assign o_zero     = r_zero;
    assign o_sel_one  = (i_ki == MY_IDX) ? r_one : '0;
    assign o_sel_zero = (i_zi == MY_IDX) ? r_zero : '0;

endmodule

`default_nettype wire

FILE: rtl/core/kofn_row.sv
`default_nettype none

module kofn_row
    import kofn_pkg::*;
#(
    parameter int MAX_VARS = DEF_MAX_VARS,
    parameter int IW       = $clog2(MAX_VARS)
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  t_cell_ctrl  i_ctrl,
    input  wire  [PROB_W-1:0] i_p,
    input  wire  [PROB_W-1:0] i_q,
    input  wire  [IW-1:0]     i_ki,
    input  wire  [IW-1:0]     i_zi,
    output logic [PROB_W-1:0] o_sel_one,
    output logic [PROB_W-1:0] o_sel_zero
);

    logic [PROB_W-1:0] w_one      [MAX_VARS];
    logic [PROB_W-1:0] w_zero     [MAX_VARS];
    logic [PROB_W-1:0] w_sel_one  [MAX_VARS];
    logic [PROB_W-1:0] w_sel_zero [MAX_VARS];

    for (genvar j = 0; j < MAX_VARS; j++) begin : g_cell
        logic [PROB_W-1:0] w_prev_one;
        logic [PROB_W-1:0] w_prev_zero;

        if (j == 0) begin : g_first
            assign w_prev_one  = '0;
            assign w_prev_zero = '0;
        end else begin : g_rest
            assign w_prev_one  = w_one[j-1];
            assign w_prev_zero = w_zero[j-1];
        end

        kofn_cell #(
            .IW       (IW),
            .CELL_IDX (j)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_p         (i_p),
            .i_q         (i_q),
            .i_prev_one  (w_prev_one),
            .i_prev_zero (w_prev_zero),
            .i_ki        (i_ki),
            .i_zi        (i_zi),
            .o_one       (w_one[j]),
            .o_zero      (w_zero[j]),
            .o_sel_one   (w_sel_one[j]),
            .o_sel_zero  (w_sel_zero[j])
        );
    end

    always_comb begin
        o_sel_one  = '0;
        o_sel_zero = '0;
        for (int j = 0; j < MAX_VARS; j++) begin
            o_sel_one  = o_sel_one | w_sel_one[j];
            o_sel_zero = o_sel_zero | w_sel_zero[j];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/kofn_expected_test_cost_top.sv
`default_nettype none

// Each input word passes through the multiply, sum, cost product and accumulate steps
// of the cell chain and the cost path before it reaches the result register, and the
// next word is accepted only once the last one has reached it, so no new word is taken
// while one is still in those steps; a held result stalls the last step.
// Reset is synchronous and active low; it restores the registers to their defaults
// and the probability rows, counters and accumulator to an empty evaluation at once.

module kofn_expected_test_cost_top
    import kofn_pkg::*;
#(
    parameter int MAX_VARS = DEF_MAX_VARS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  t_in_word       i_in_word,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output t_out_word            o_out_word,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW    = $clog2(MAX_VARS);
    localparam int CNT_W = ($clog2(MAX_VARS + 1) > CFG_DATA_W) ?
                           $clog2(MAX_VARS + 1) : CFG_DATA_W;
    localparam logic [CNT_W-1:0]  MAX_N     = CNT_W'(MAX_VARS);
    localparam logic [CNT_W-1:0]  IDX_MASK  = CNT_W'(MAX_VARS - 1);
    localparam logic [COST_W-1:0] COST_MASK = COST_W'((64'd1 << COST_BITS) - 1);
    localparam logic [ACC_W-1:0]  ACC_MAX   = '1;

    t_state r_state;
    t_state n_state;

    logic [CFG_DATA_W-1:0] r_threshold_k;
    logic [CFG_DATA_W-1:0] r_variable_count;
    logic                  r_cost_mode;

    logic [PROB_W-1:0]   r_p;
    logic [PROB_W-1:0]   r_q;
    logic [IW-1:0]       r_ki;
    logic [IW-1:0]       r_zi;
    logic                r_final;
    logic [CNT_W-1:0]    r_items_seen;
    logic [PREFIX_W-1:0] r_prefix;
    logic [PROB_W-1:0]   r_sa;
    logic [PROB_W-1:0]   r_sb;
    logic [PROB_W-1:0]   r_settle;
    logic [TERM_W-1:0]   r_term;
    logic [ACC_W-1:0]    r_acc;
    logic                r_out_valid;
    t_out_word           r_out_word;

    t_cell_ctrl        w_ctrl;
    logic              w_accept;
    logic              w_out_free;
    logic              w_acc_load;
    logic [PROB_W-1:0] w_sel_one;
    logic [PROB_W-1:0] w_sel_zero;

    logic [CNT_W-1:0]    w_n;
    logic [CNT_W-1:0]    w_k;
    logic [CNT_W-1:0]    w_n_raw;
    logic [CNT_W-1:0]    w_k_raw;
    logic [PROB_W-1:0]   w_p;
    logic [COST_W-1:0]   w_cost;
    logic [PREFIX_W:0]   w_prefix_sum;
    logic [PREFIX_W-1:0] n_prefix;
    logic [ACC_W:0]      w_acc_sum;
    logic [ACC_W-1:0]    n_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_k    <= CFG_DATA_W'(1);
            r_variable_count <= CFG_DATA_W'(1);
            r_cost_mode      <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_THRESHOLD_K) begin
                r_threshold_k <= i_cfg_data;
            end else if (i_cfg_index == REG_VARIABLE_COUNT) begin
                r_variable_count <= i_cfg_data;
            end else if (i_cfg_index == REG_COST_MODE) begin
                r_cost_mode <= i_cfg_data[0];
            end
        end
    end

    always_comb begin
        w_n_raw = CNT_W'(r_variable_count);
        w_k_raw = CNT_W'(r_threshold_k);
        if (w_n_raw == '0) begin
            w_n = CNT_W'(1);
        end else if (w_n_raw > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = w_n_raw;
        end
        if (w_k_raw == '0) begin
            w_k = CNT_W'(1);
        end else if (w_k_raw > w_n) begin
            w_k = w_n;
        end else begin
            w_k = w_k_raw;
        end
    end

    assign w_p    = (i_in_word.probability_one > PROB_ONE) ? PROB_ONE
                                                           : i_in_word.probability_one;
    assign w_cost = r_cost_mode ? (i_in_word.test_cost & COST_MASK) : COST_W'(1);
    assign w_prefix_sum = {1'b0, r_prefix} + (PREFIX_W + 1)'(w_cost);
    assign n_prefix     = w_prefix_sum[PREFIX_W] ? '1 : w_prefix_sum[PREFIX_W-1:0];

    assign w_acc_sum = {1'b0, r_acc} + (ACC_W + 1)'(r_term);
    assign n_acc     = w_acc_sum[ACC_W] ? ACC_MAX : w_acc_sum[ACC_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_TERM;
            S_TERM: n_state = S_ACC;
            S_ACC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_in_ready    = 1'b0;
        w_ctrl.mul_en = 1'b0;
        w_ctrl.upd_en = 1'b0;
        w_ctrl.clr    = 1'b0;
        w_acc_load    = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready    = 1'b1;
            S_MUL:  w_ctrl.mul_en = 1'b1;
            S_SUM:  w_ctrl.upd_en = 1'b1;
            S_TERM: w_acc_load    = 1'b0;
            S_ACC: begin
                w_acc_load = w_out_free;
                w_ctrl.clr = w_out_free && r_final;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p     <= w_p;
            r_q     <= PROB_ONE - w_p;
            r_ki    <= IW'((w_k - CNT_W'(1)) & IDX_MASK);
            r_zi    <= IW'((w_n - w_k) & IDX_MASK);
            r_final <= (r_items_seen + CNT_W'(1)) >= w_n;
        end
        if (w_ctrl.mul_en) begin
            r_sa <= pmul(w_sel_one, r_p);
            r_sb <= pmul(w_sel_zero, r_q);
        end
        if (w_ctrl.upd_en) begin
            r_settle <= psat_add(r_sa, r_sb);
        end
        if (r_state == S_TERM) begin
            r_term <= r_settle * r_prefix;
        end
        if (w_acc_load) begin
            r_out_word.running_cost <= n_acc;
            r_out_word.final_item   <= r_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix     <= '0;
            r_acc        <= '0;
            r_items_seen <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_prefix <= n_prefix;
            end
            if (w_acc_load) begin
                if (r_final) begin
                    r_prefix     <= '0;
                    r_acc        <= '0;
                    r_items_seen <= '0;
                end else begin
                    r_acc        <= n_acc;
                    r_items_seen <= r_items_seen + CNT_W'(1);
                end
            end
            if (w_acc_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    kofn_row #(
        .MAX_VARS (MAX_VARS),
        .IW       (IW)
    ) u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_p        (r_p),
        .i_q        (r_q),
        .i_ki       (r_ki),
        .i_zi       (r_zi),
        .o_sel_one  (w_sel_one),
        .o_sel_zero (w_sel_zero)
    );

endmodule

`default_nettype wire
